// File: src/ncpe_pkg.sv
// shared constants and types of the nurbs curve point evaluator
package ncpe_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_DEGREE_DEF = 7;

    localparam int ONE_Q16 = 65536;
    localparam int NUM_W   = 58;   // dividend magnitude bits
    localparam int DEN_W   = 26;   // divisor magnitude bits

    localparam int S_DATA_W = 168;
    localparam int M_DATA_W = 104;

    typedef enum logic [1:0] {
        OP_LOAD_KNOT  = 2'd0,
        OP_LOAD_POINT = 2'd1,
        OP_EVAL       = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPAN   = 2'd1,
        ST_ZERO_DIV  = 2'd2,
        ST_SAT       = 2'd3
    } status_t;

    localparam logic CFG_DEGREE = 1'b0;
    localparam logic CFG_POINTS = 1'b1;

    typedef struct packed {
        logic        [23:0] w;
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } point_t;

    typedef struct packed {
        logic        [25:0] w;
        logic signed [57:0] z;
        logic signed [57:0] y;
        logic signed [57:0] x;
    } work_t;

endpackage

// File: src/nurbs_curve_point_evaluator_unit.sv
// top level: rational b-spline curve point evaluator by de boor's algorithm
// load items give no result; the block stays ready for the next item
// an evaluate item is dominated by the serial divider, which runs once for each alpha
// and once for each output coordinate
// only one item is worked on at a time; the result waits in an output register
// reset (aresetn, synchronous, active low) sets degree 3, point count 4; tables are not cleared
module nurbs_curve_point_evaluator_unit import ncpe_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // fields from bit 0: operation[2], slot_index[7], knot_value[17], coord_x[32],
    // coord_y[32], coord_z[32], point_weight[24], param_u[19], zero fill[3]
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // fields from bit 0: out_x[32], out_y[32], out_z[32], status[2], zero fill[6]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // configuration write port
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [6:0]          cfg_data
);

    localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1;
    localparam int KAW  = $clog2(KNOT_DEPTH);
    localparam int PAW  = $clog2(MAX_POINTS);
    localparam int WAW  = $clog2(MAX_DEGREE + 1);
    localparam int CW   = $clog2(KNOT_DEPTH + 1);
    localparam int PCW  = $clog2(MAX_POINTS + 1);
    localparam int WDEP = MAX_DEGREE + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_SRD, S_SCHK, S_SPCHK, S_PRD, S_PCAP, S_PMUL, S_PWR,
        S_BK0, S_BK1, S_BK2, S_BDIV, S_BW0, S_BW1, S_BW2, S_BMUL,
        S_FRD, S_FCHK, S_FDIV, S_EMIT
    } state_t;

    // input fields
    logic [1:0]         in_op;
    logic [6:0]         in_slot;
    logic [16:0]        in_knot;
    point_t             in_point;
    logic signed [18:0] in_u;

    assign in_op      = s_tdata[1:0];
    assign in_slot    = s_tdata[8:2];
    assign in_knot    = s_tdata[25:9];
    assign in_point.x = s_tdata[57:26];
    assign in_point.y = s_tdata[89:58];
    assign in_point.z = s_tdata[121:90];
    assign in_point.w = s_tdata[145:122];
    assign in_u       = s_tdata[164:146];

    state_t      state_reg;
    logic [2:0]  degree_reg;
    logic [6:0]  points_reg;

    // evaluation context
    logic [16:0]    u_reg;
    logic [WAW-1:0] d_reg;
    logic [PCW-1:0] pc_reg;
    logic [CW-1:0]  nk_reg;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  span_reg;
    logic [16:0]    kprev_reg;
    logic [16:0]    klo_reg;
    logic [WAW-1:0] j_reg;
    logic [WAW-1:0] r_reg;
    logic [1:0]     comp_reg;
    logic           half_reg;
    logic [16:0]    alpha_reg;
    point_t         pt_reg;
    work_t          acc_reg;
    work_t          left_reg;
    work_t          right_reg;
    work_t          fin_reg;
    logic signed [31:0] res_x_reg, res_y_reg, res_z_reg;
    status_t        st_reg;
    logic           sat_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic           m_tvalid_reg;

    logic accept;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // tables
    logic           knot_we;
    logic [KAW-1:0] knot_raddr;
    logic [16:0]    knot_rdata;
    logic           pt_we;
    logic [PAW-1:0] pt_raddr;
    point_t         pt_rdata;
    logic           work_we;
    logic [WAW-1:0] work_waddr, work_raddr;
    work_t          work_wdata, work_rdata;

    assign knot_we = accept && in_op == OP_LOAD_KNOT && int'(in_slot) < KNOT_DEPTH;
    assign pt_we   = accept && in_op == OP_LOAD_POINT && int'(in_slot) < MAX_POINTS;

    ncpe_ram #(.WIDTH(17), .DEPTH(KNOT_DEPTH)) u_knot_ram (
        .aclk(aclk), .we(knot_we), .waddr(KAW'(in_slot)), .wdata(in_knot),
        .raddr(knot_raddr), .rdata(knot_rdata)
    );

    ncpe_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_POINTS)) u_point_ram (
        .aclk(aclk), .we(pt_we), .waddr(PAW'(in_slot)), .wdata(in_point),
        .raddr(pt_raddr), .rdata(pt_rdata)
    );

    ncpe_ram #(.WIDTH($bits(work_t)), .DEPTH(WDEP)) u_work_ram (
        .aclk(aclk), .we(work_we), .waddr(work_waddr), .wdata(work_wdata),
        .raddr(work_raddr), .rdata(work_rdata)
    );

    // knot and point indexes of the current triangle step
    logic [CW-1:0] lo_idx, hi_idx;
    assign lo_idx = span_reg + CW'(j_reg) - CW'(d_reg);
    assign hi_idx = span_reg + CW'(j_reg) + CW'(1) - CW'(r_reg);

    // shared divider
    logic                div_start, div_busy, div_done, div_neg;
    logic signed [NUM_W:0] div_dvd;
    logic signed [DEN_W:0] div_dvs;
    logic [NUM_W-1:0]      div_mag;

    ncpe_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_dvd),
        .divisor(div_dvs), .busy(div_busy), .done(div_done), .quo_mag(div_mag),
        .neg(div_neg)
    );

    // alpha denominator from the two knots, numerator from u and the lower knot
    logic signed [17:0] den, num;
    assign den = $signed({1'b0, knot_rdata}) - $signed({1'b0, klo_reg});
    assign num = $signed({1'b0, u_reg}) - $signed({1'b0, klo_reg});

    function automatic logic signed [57:0] wsel(work_t w, logic [1:0] c);
        logic signed [57:0] v;
        case (c)
            2'd0:    v = w.x;
            2'd1:    v = w.y;
            default: v = w.z;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] psel(point_t p, logic [1:0] c);
        logic signed [31:0] v;
        case (c)
            2'd0:    v = p.x;
            2'd1:    v = p.y;
            default: v = p.z;
        endcase
        return v;
    endfunction

    always_comb begin
        div_start = 1'b0;
        div_dvd   = {{(NUM_W - 33){num[17]}}, num, 16'b0};
        div_dvs   = {{(DEN_W - 17){den[17]}}, den};
        if (state_reg == S_BK2) begin
            div_start = (den != '0);
        end else if (state_reg == S_FCHK) begin
            div_start = (work_rdata.w != '0);
            div_dvd   = {work_rdata.x[57], work_rdata.x};
            div_dvs   = {1'b0, work_rdata.w};
        end else if (state_reg == S_FDIV) begin
            div_start = div_done && comp_reg != 2'd2;
            div_dvd   = (comp_reg == 2'd0) ? {fin_reg.y[57], fin_reg.y}
                                           : {fin_reg.z[57], fin_reg.z};
            div_dvs   = {1'b0, fin_reg.w};
        end
    end

    // alpha clamp: negative quotient gives zero, above one gives one
    logic [16:0] alpha_c;
    assign alpha_c = div_neg ? 17'd0 :
                     (div_mag > NUM_W'(ONE_Q16)) ? 17'(ONE_Q16) : div_mag[16:0];

    // final coordinate saturation
    logic signed [31:0] sat_val;
    logic               sat_hit;
    always_comb begin
        sat_hit = 1'b0;
        if (div_neg) begin
            if (div_mag > NUM_W'(64'h8000_0000)) begin
                sat_hit = 1'b1;
                sat_val = 32'sh8000_0000;
            end else begin
                sat_val = 32'(-div_mag);
            end
        end else if (div_mag > NUM_W'(64'h7FFF_FFFF)) begin
            sat_hit = 1'b1;
            sat_val = 32'sh7FFF_FFFF;
        end else begin
            sat_val = div_mag[31:0];
        end
    end

    // shared multiplier: weighting as points are read in, blend on the triangle
    logic signed [58:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [76:0] prod;
    logic signed [57:0] blend_left;
    logic signed [57:0] blend_res;

    always_comb begin
        if (state_reg == S_PMUL) begin
            mul_a = 59'(psel(pt_reg, comp_reg));
            mul_b = half_reg ? $signed({10'b0, pt_reg.w[23:16]})
                             : $signed({2'b0, pt_reg.w[15:0]});
        end else if (comp_reg == 2'd3) begin
            mul_a = $signed({33'b0, right_reg.w}) - $signed({33'b0, left_reg.w});
            mul_b = $signed({1'b0, alpha_reg});
        end else begin
            mul_a = 59'(wsel(right_reg, comp_reg)) - 59'(wsel(left_reg, comp_reg));
            mul_b = $signed({1'b0, alpha_reg});
        end
        prod = mul_a * mul_b;
    end

    // floor((l*(1-a) + r*a)) = l + floor((r-l)*a)
    assign blend_left = (comp_reg == 2'd3) ? $signed({32'b0, left_reg.w})
                                           : wsel(left_reg, comp_reg);
    assign blend_res  = blend_left + prod[73:16];

    // ram addressing
    always_comb begin
        knot_raddr = '0;
        pt_raddr   = PAW'(lo_idx);
        work_raddr = j_reg;
        work_we    = 1'b0;
        work_waddr = j_reg;
        work_wdata = acc_reg;
        case (state_reg)
            S_SRD:  knot_raddr = KAW'(cnt_reg);
            S_BK0:  knot_raddr = KAW'(lo_idx);
            S_BK1:  knot_raddr = KAW'(hi_idx);
            S_BW0:  work_raddr = j_reg - WAW'(1);
            S_FRD:  work_raddr = d_reg;
            S_PWR:  work_we = 1'b1;
            S_BMUL: begin
                work_we    = (comp_reg == 2'd3);
                work_wdata = acc_reg;
                work_wdata.w = blend_res[25:0];
            end
            default: ;
        endcase
    end

    logic [16:0] u_clamp;
    assign u_clamp = in_u[18] ? 17'd0 :
                     (in_u > 19'sd65536) ? 17'(ONE_Q16) : in_u[16:0];

    logic hit;
    assign hit = (u_reg != 17'(ONE_Q16))
               ? (u_reg >= kprev_reg && u_reg < knot_rdata)
               : (u_reg > kprev_reg && u_reg <= knot_rdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            degree_reg   <= 3'd3;
            points_reg   <= 7'd4;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_DEGREE) begin
                    degree_reg <= cfg_data[2:0];
                end else begin
                    points_reg <= cfg_data;
                end
            end
            // a new result loaded in the emit state takes the place of this one
            if (m_tvalid_reg && m_tready && state_reg != S_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept && in_op == OP_EVAL) begin
                        u_reg    <= u_clamp;
                        d_reg    <= (int'(degree_reg) > MAX_DEGREE) ? WAW'(MAX_DEGREE)
                                                                    : WAW'(degree_reg);
                        pc_reg   <= (int'(points_reg) > MAX_POINTS) ? PCW'(MAX_POINTS)
                                                                    : PCW'(points_reg);
                        nk_reg   <= CW'(((int'(points_reg) > MAX_POINTS) ? MAX_POINTS
                                     : int'(points_reg))
                                   + ((int'(degree_reg) > MAX_DEGREE) ? MAX_DEGREE
                                     : int'(degree_reg)) + 1);
                        cnt_reg  <= '0;
                        span_reg <= '0;
                        sat_reg  <= 1'b0;
                        state_reg <= S_SRD;
                    end
                end
                S_SRD: begin
                    // fewer than two knots: span stays zero
                    state_reg <= (nk_reg < CW'(2)) ? S_SPCHK : S_SCHK;
                end
                S_SCHK: begin
                    kprev_reg <= knot_rdata;
                    if (cnt_reg != '0 && hit) begin
                        span_reg  <= cnt_reg - CW'(1);
                        state_reg <= S_SPCHK;
                    end else if (cnt_reg == nk_reg - CW'(1)) begin
                        res_x_reg <= '0;
                        res_y_reg <= '0;
                        res_z_reg <= '0;
                        st_reg    <= ST_NO_SPAN;
                        state_reg <= S_EMIT;
                    end else begin
                        cnt_reg   <= cnt_reg + CW'(1);
                        state_reg <= S_SRD;
                    end
                end
                S_SPCHK: begin
                    if (span_reg < CW'(d_reg) || int'(span_reg) >= int'(pc_reg)) begin
                        res_x_reg <= '0;
                        res_y_reg <= '0;
                        res_z_reg <= '0;
                        st_reg    <= ST_NO_SPAN;
                        state_reg <= S_EMIT;
                    end else begin
                        j_reg     <= '0;
                        state_reg <= S_PRD;
                    end
                end
                S_PRD: state_reg <= S_PCAP;
                S_PCAP: begin
                    pt_reg    <= pt_rdata;
                    comp_reg  <= 2'd0;
                    half_reg  <= 1'b0;
                    state_reg <= S_PMUL;
                end
                S_PMUL: begin
                    // weighted coordinate: low weight half, then high half shifted
                    case (comp_reg)
                        2'd0: acc_reg.x <= half_reg ? acc_reg.x + {prod[41:0], 16'b0}
                                                    : prod[57:0];
                        2'd1: acc_reg.y <= half_reg ? acc_reg.y + {prod[41:0], 16'b0}
                                                    : prod[57:0];
                        default: acc_reg.z <= half_reg ? acc_reg.z + {prod[41:0], 16'b0}
                                                       : prod[57:0];
                    endcase
                    acc_reg.w <= {2'b0, pt_reg.w};
                    half_reg  <= ~half_reg;
                    if (half_reg) begin
                        comp_reg <= comp_reg + 2'd1;
                        if (comp_reg == 2'd2) begin
                            state_reg <= S_PWR;
                        end
                    end
                end
                S_PWR: begin
                    if (j_reg == d_reg) begin
                        r_reg     <= WAW'(1);
                        state_reg <= (d_reg == '0) ? S_FRD : S_BK0;
                    end else begin
                        j_reg     <= j_reg + WAW'(1);
                        state_reg <= S_PRD;
                    end
                end
                S_BK0: state_reg <= S_BK1;
                S_BK1: begin
                    klo_reg   <= knot_rdata;
                    state_reg <= S_BK2;
                end
                S_BK2: begin
                    if (den == '0) begin
                        res_x_reg <= '0;
                        res_y_reg <= '0;
                        res_z_reg <= '0;
                        st_reg    <= ST_ZERO_DIV;
                        state_reg <= S_EMIT;
                    end else begin
                        state_reg <= S_BDIV;
                    end
                end
                S_BDIV: begin
                    if (div_done) begin
                        alpha_reg <= alpha_c;
                        state_reg <= S_BW0;
                    end
                end
                S_BW0: state_reg <= S_BW1;
                S_BW1: begin
                    left_reg  <= work_rdata;
                    state_reg <= S_BW2;
                end
                S_BW2: begin
                    right_reg <= work_rdata;
                    comp_reg  <= 2'd0;
                    state_reg <= S_BMUL;
                end
                S_BMUL: begin
                    case (comp_reg)
                        2'd0:    acc_reg.x <= blend_res;
                        2'd1:    acc_reg.y <= blend_res;
                        2'd2:    acc_reg.z <= blend_res;
                        default: acc_reg.w <= blend_res[25:0];
                    endcase
                    comp_reg <= comp_reg + 2'd1;
                    if (comp_reg == 2'd3) begin
                        // next triangle step: j runs down to r, then r steps up
                        if (j_reg == r_reg) begin
                            if (r_reg == d_reg) begin
                                state_reg <= S_FRD;
                            end else begin
                                r_reg     <= r_reg + WAW'(1);
                                j_reg     <= d_reg;
                                state_reg <= S_BK0;
                            end
                        end else begin
                            j_reg     <= j_reg - WAW'(1);
                            state_reg <= S_BK0;
                        end
                    end
                end
                S_FRD: state_reg <= S_FCHK;
                S_FCHK: begin
                    fin_reg  <= work_rdata;
                    comp_reg <= 2'd0;
                    if (work_rdata.w == '0) begin
                        res_x_reg <= '0;
                        res_y_reg <= '0;
                        res_z_reg <= '0;
                        st_reg    <= ST_ZERO_DIV;
                        state_reg <= S_EMIT;
                    end else begin
                        state_reg <= S_FDIV;
                    end
                end
                S_FDIV: begin
                    if (div_done) begin
                        case (comp_reg)
                            2'd0:    res_x_reg <= sat_val;
                            2'd1:    res_y_reg <= sat_val;
                            default: res_z_reg <= sat_val;
                        endcase
                        comp_reg <= comp_reg + 2'd1;
                        if (comp_reg == 2'd2) begin
                            st_reg    <= (sat_reg || sat_hit) ? ST_SAT : ST_OK;
                            state_reg <= S_EMIT;
                        end else begin
                            sat_reg <= sat_reg || sat_hit;
                        end
                    end
                end
                S_EMIT: begin
                    // wait for the output register to free up
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg[95:0]   <= {res_z_reg, res_y_reg, res_x_reg};
                        m_tdata_reg[97:96]  <= st_reg;
                        m_tdata_reg[103:98] <= '0;
                        m_tvalid_reg        <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[97:96] == ST_NO_SPAN || m_tdata[97:96] == ST_ZERO_DIV)
        |-> m_tdata[95:0] == '0)
        else $error("failed evaluation carries nonzero coordinates");

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_alpha_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_BW0 |-> alpha_reg <= 17'(ONE_Q16))
        else $error("alpha above one");

    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[1:0] == OP_EVAL |=> !s_tready)
        else $error("ready while evaluating");

endmodule

// File: src/ncpe_ram.sv
// generic single-port-write ram with registered read
module ncpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/ncpe_div.sv
// bit-serial restoring divider on magnitudes, one quotient bit per cycle
module ncpe_div import ncpe_pkg::*; #(
    parameter int NW = NUM_W,
    parameter int DW = DEN_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [NW:0]  dividend,
    input  logic signed [DW:0]  divisor,
    output logic                busy,
    output logic                done,
    output logic [NW-1:0]       quo_mag,
    output logic                neg
);

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   num_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   dvs_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic            neg_reg;

    logic signed [NW:0] dvd_abs;
    logic signed [DW:0] dvs_abs;
    logic [DW:0]        trial;
    logic               fits;

    assign dvd_abs = dividend[NW] ? -dividend : dividend;
    assign dvs_abs = divisor[DW] ? -divisor : divisor;
    assign trial   = {rem_reg, num_reg[NW-1]};
    assign fits    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                num_reg  <= dvd_abs[NW-1:0];
                dvs_reg  <= dvs_abs[DW-1:0];
                rem_reg  <= '0;
                neg_reg  <= dividend[NW] ^ divisor[DW];
                cnt_reg  <= CNTW'(NW);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? DW'(trial - {1'b0, dvs_reg}) : trial[DW-1:0];
                num_reg <= {num_reg[NW-2:0], fits};
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign quo_mag = num_reg;
    assign neg     = neg_reg;

endmodule

// File: sim/tb.sv
// testbench for the nurbs curve point evaluator: directed rows, then random phases
`timescale 1ns / 1ps

module tb;
    import ncpe_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;     // undefined operation, dropped by the block
    localparam int KNOT_SLOTS  = MAX_POINTS_DEF + MAX_DEGREE_DEF + 1;
    localparam int PT_SLOTS    = MAX_POINTS_DEF;

    typedef struct {
        logic [1:0]         op;
        logic [6:0]         slot;
        logic [16:0]        knot;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [23:0]        w;
        logic signed [18:0] u;
    } nurbs_item_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        status_t            st;
    } curve_pt_t;

    // directed row: item plus an optional expected point typed in by hand
    typedef struct {
        nurbs_item_t it;
        bit          typed;
        curve_pt_t   pt;
    } opening_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_index = CFG_DEGREE;
    logic [6:0]          cfg_data = '0;

    always #4 aclk = ~aclk;

    nurbs_curve_point_evaluator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor copy of the block state
    logic [6:0]  deg_reg, pts_reg;
    longint      knot_mem[KNOT_SLOTS];
    longint      px_mem[PT_SLOTS], py_mem[PT_SLOTS], pz_mem[PT_SLOTS];
    longint      pw_mem[PT_SLOTS];

    curve_pt_t   curve_pts_due[$];
    curve_pt_t   nil_pt;
    int          mismatch_cnt = 0;
    int          results_seen = 0;
    int          evals_sent = 0;
    int          loads_sent = 0;
    int          send_idle = 0;    // percent of cycles the sender holds back
    int          recv_stall = 0;   // percent of cycles the receiver stalls

    // floor((p*(1-a) + q*a) / 2^16) at full width
    function automatic longint blend_q16(longint p, longint q, int a);
        logic signed [127:0] lp, lq, acc;
        lp = p;
        lq = q;
        acc = lp * (65536 - a) + lq * a;
        return longint'(acc >>> 16);
    endfunction

    function automatic logic signed [31:0] clip32(longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // updates the table copy for loads; for an evaluate works out the curve point
    function automatic bit eval_curve_item(nurbs_item_t it, output curve_pt_t pt);
        int     d, pc, nk, span, a;
        longint uu, num, den, q, wd;
        longint wx[8], wy[8], wz[8];
        longint ww[8];
        bit     sat;
        pt = '{0, 0, 0, ST_OK};
        case (it.op)
            OP_LOAD_KNOT: begin
                if (it.slot < KNOT_SLOTS) knot_mem[it.slot] = it.knot;
                return 1'b0;
            end
            OP_LOAD_POINT: begin
                if (it.slot < PT_SLOTS) begin
                    px_mem[it.slot] = it.x;
                    py_mem[it.slot] = it.y;
                    pz_mem[it.slot] = it.z;
                    pw_mem[it.slot] = it.w;
                end
                return 1'b0;
            end
            OP_EVAL: ;
            default: return 1'b0;
        endcase
        d  = deg_reg[2:0] > MAX_DEGREE_DEF ? MAX_DEGREE_DEF : deg_reg[2:0];
        pc = pts_reg > MAX_POINTS_DEF ? MAX_POINTS_DEF : pts_reg;
        nk = pc + d + 1;
        uu = it.u;
        if (uu < 0) uu = 0;
        if (uu > ONE_Q16) uu = ONE_Q16;
        span = -1;
        if (nk < 2) span = 0;
        else begin
            for (int i = 0; i + 1 < nk; i++) begin
                if ((uu < ONE_Q16) ? (uu >= knot_mem[i] && uu < knot_mem[i+1])
                                   : (uu > knot_mem[i] && uu <= knot_mem[i+1])) begin
                    span = i;
                    break;
                end
            end
        end
        if (span < d || span > pc - 1) begin
            pt.st = ST_NO_SPAN;
            return 1'b1;
        end
        for (int j = 0; j <= d; j++) begin
            ww[j] = pw_mem[j + span - d];
            wx[j] = px_mem[j + span - d] * ww[j];
            wy[j] = py_mem[j + span - d] * ww[j];
            wz[j] = pz_mem[j + span - d] * ww[j];
        end
        for (int r = 1; r <= d; r++) begin
            for (int j = d; j >= r; j--) begin
                num = uu - knot_mem[j + span - d];
                den = knot_mem[j + 1 + span - r] - knot_mem[j + span - d];
                if (den == 0) begin
                    pt.st = ST_ZERO_DIV;
                    return 1'b1;
                end
                q = (num * ONE_Q16) / den;
                if (q < 0) q = 0;
                if (q > ONE_Q16) q = ONE_Q16;
                a = int'(q);
                wx[j] = blend_q16(wx[j-1], wx[j], a);
                wy[j] = blend_q16(wy[j-1], wy[j], a);
                wz[j] = blend_q16(wz[j-1], wz[j], a);
                ww[j] = (ww[j-1] * (65536 - a) + ww[j] * a) >>> 16;
            end
        end
        if (ww[d] == 0) begin
            pt.st = ST_ZERO_DIV;
            return 1'b1;
        end
        wd = ww[d];
        sat = 1'b0;
        pt.x = clip32(wx[d] / wd, sat);
        pt.y = clip32(wy[d] / wd, sat);
        pt.z = clip32(wz[d] / wd, sat);
        pt.st = sat ? ST_SAT : ST_OK;
        return 1'b1;
    endfunction

    // one item onto the input channel; expectation logged when accepted
    task automatic push_item(nurbs_item_t it, bit typed = 1'b0,
                             curve_pt_t typed_pt = '{0, 0, 0, ST_OK});
        curve_pt_t pt;
        while ($urandom_range(99) < send_idle) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b0, it.u, it.w, it.z, it.y, it.x, it.knot, it.slot, it.op};
        do @(posedge aclk); while (!s_tready);
        if (eval_curve_item(it, pt)) begin
            curve_pts_due.insert(curve_pts_due.size(), typed ? typed_pt : pt);
            evals_sent++;
        end else begin
            loads_sent++;
        end
    endtask

    // sender holds back until every point has come out, plus a short settle
    task automatic drain_block();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (curve_pts_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_DEGREE) deg_reg = val & 7'd7;
        else pts_reg = val;
    endtask

    function automatic nurbs_item_t knot_item(int slot, int val);
        return '{OP_LOAD_KNOT, 7'(slot), 17'(val), 0, 0, 0, 0, 0};
    endfunction

    function automatic nurbs_item_t point_item(int slot, int x, int y, int z, int w);
        return '{OP_LOAD_POINT, 7'(slot), 0, x, y, z, 24'(w), 0};
    endfunction

    function automatic nurbs_item_t eval_item(int u);
        return '{OP_EVAL, 0, 0, 0, 0, 0, 0, 19'(u)};
    endfunction

    function automatic nurbs_item_t rand_point(int slot);
        nurbs_item_t it;
        it = point_item(slot, $urandom, $urandom, $urandom, $urandom_range(24'hffffff, 1));
        // mostly moderate weights, and in a third of points moderate x and y, so curves stay meaningful
        if ($urandom_range(3) != 0) it.w = $urandom_range(24'h40000, 24'h1000);
        if ($urandom_range(2) == 0) begin
            it.x = $signed($urandom_range(32'h00ffffff)) - 32'sh00800000;
            it.y = $signed($urandom_range(32'h00ffffff)) - 32'sh00800000;
        end
        if ($urandom_range(40) == 0) it.w = 0;
        return it;
    endfunction

    function automatic int rand_u();
        case ($urandom_range(9))
            0: return $urandom_range(131072) - 131072;
            1: return $urandom_range(131072, 65536);
            2: return ($urandom_range(1)) ? 0 : 65536;
            default: return $urandom_range(65536);
        endcase
    endfunction

    // result channel: random stall, field-by-field compare at the edge
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_stall);

    always @(posedge aclk) begin
        curve_pt_t exp_pt;
        curve_pt_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], status_t'(m_tdata[97:96])};
            results_seen++;
            if (curve_pts_due.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("tb: point out with none expected: %p", got);
            end else begin
                exp_pt = curve_pts_due.pop_front();
                if (got.x !== exp_pt.x || got.y !== exp_pt.y || got.z !== exp_pt.z ||
                        got.st !== exp_pt.st) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"tb: mismatch exp x=%0d y=%0d z=%0d st=%s",
                                  " got x=%0d y=%0d z=%0d st=%s"},
                            exp_pt.x, exp_pt.y, exp_pt.z, exp_pt.st.name(),
                            got.x, got.y, got.z, got.st.name());
                end
            end
        end
    end

    // watchdog
    initial begin
        #200_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        opening_row_t rows[$];
        int           phase_deg[11] = '{1, 0, 0, 2, 7, 5, 3, 4, 6, 1, 3};
        int           phase_pts[11] = '{2, 0, 1, 5, 127, 10, 64, 20, 7, 30, 4};
        int           phase_len[11] = '{40, 15, 20, 50, 20, 55, 35, 50, 40, 70, 65};
        int           d, pc, nk, kv, pick;
        nurbs_item_t  it;

        nil_pt  = '{0, 0, 0, ST_OK};
        deg_reg = 7'd3;
        pts_reg = 7'd4;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset values: degree 3, four points, bezier knot vector
        for (int i = 0; i < 8; i++)
            rows.insert(rows.size(), '{knot_item(i, i < 4 ? 0 : 65536), 1'b0, nil_pt});
        rows.insert(rows.size(), '{point_item(0, 32'sh80000000, 32'sh7fffffff, 0, 24'hffffff),
                                   1'b0, nil_pt});
        rows.insert(rows.size(), '{point_item(1, 32'sh00100000, 32'shfff00000, 32'sh7fffffff,
                                              24'h010000), 1'b0, nil_pt});
        rows.insert(rows.size(), '{point_item(2, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                                              24'h000001), 1'b0, nil_pt});
        rows.insert(rows.size(), '{point_item(3, 65536, -65536, 12345, 24'h010000),
                                   1'b0, nil_pt});
        // clamped u below 0 and above 1 land on the end points
        rows.insert(rows.size(), '{eval_item(-131072), 1'b1,
                                   '{32'sh80000000, 32'sh7fffffff, 0, ST_OK}});
        rows.insert(rows.size(), '{eval_item(0), 1'b1,
                                   '{32'sh80000000, 32'sh7fffffff, 0, ST_OK}});
        rows.insert(rows.size(), '{eval_item(65536), 1'b1, '{65536, -65536, 12345, ST_OK}});
        rows.insert(rows.size(), '{eval_item(131072), 1'b1, '{65536, -65536, 12345, ST_OK}});
        rows.insert(rows.size(), '{eval_item(32768), 1'b0, nil_pt});
        // dropped items: undefined operation and loads past the tables
        rows.insert(rows.size(), '{'{OP_NONE, 7'h7f, 17'h1ffff, -1, -1, -1, 24'hffffff, -1},
                                   1'b0, nil_pt});
        rows.insert(rows.size(), '{knot_item(KNOT_SLOTS, 17'h1ffff), 1'b0, nil_pt});
        rows.insert(rows.size(), '{knot_item(127, 0), 1'b0, nil_pt});
        rows.insert(rows.size(), '{point_item(PT_SLOTS, 0, 0, 0, 0), 1'b0, nil_pt});
        rows.insert(rows.size(), '{eval_item(16384), 1'b0, nil_pt});
        // zero first weight gives a zero final weight at u = 0
        rows.insert(rows.size(), '{point_item(0, 32'sh80000000, 32'sh7fffffff, 0, 0),
                                   1'b0, nil_pt});
        rows.insert(rows.size(), '{eval_item(0), 1'b1, '{0, 0, 0, ST_ZERO_DIV}});
        // knot moved so the span falls below the degree
        rows.insert(rows.size(), '{knot_item(3, 65536), 1'b0, nil_pt});
        rows.insert(rows.size(), '{eval_item(32768), 1'b1, '{0, 0, 0, ST_NO_SPAN}});
        rows.insert(rows.size(), '{knot_item(3, 0), 1'b0, nil_pt});

        foreach (rows[i]) push_item(rows[i].it, rows[i].typed, rows[i].pt);

        for (int ph = 0; ph < 11; ph++) begin
            drain_block();
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 65; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 65; end
                default: begin send_idle = 32; recv_stall = 32; end
            endcase
            write_reg(CFG_DEGREE, 7'(phase_deg[ph]));
            write_reg(CFG_POINTS, 7'(phase_pts[ph]));
            d  = phase_deg[ph];
            pc = phase_pts[ph] > MAX_POINTS_DEF ? MAX_POINTS_DEF : phase_pts[ph];
            nk = pc + d + 1;

            // full knot vector, clamped or open, never decreasing
            kv = 0;
            pick = $urandom_range(2);
            for (int i = 0; i < nk; i++) begin
                if (pick != 0 && i <= d) kv = 0;
                else if (pick != 0 && i >= nk - d - 1) kv = 65536;
                else kv = kv + $urandom_range(2 * 65536 / nk);
                if (kv > 65536) kv = 65536;
                push_item(knot_item(i, kv));
            end
            for (int i = 0; i < pc; i++) push_item(rand_point(i));

            for (int n = 0; n < phase_len[ph]; n++) begin
                pick = $urandom_range(99);
                if (pick < 60) it = eval_item(rand_u());
                else if (pick < 75) it = knot_item($urandom_range(127), $urandom_range(65536));
                else if (pick < 93) it = rand_point($urandom_range(127));
                else begin
                    it = '{OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom};
                end
                push_item(it);
            end
        end

        drain_block();
        repeat (50) @(posedge aclk);
        $display("tb: %0d loads or dropped items and %0d evaluations over 11 register set-ups,",
            loads_sent, evals_sent);
        $display("tb: degree 0..7, point count 0..127, %0d points checked", results_seen);
        if (mismatch_cnt == 0 && curve_pts_due.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// File: sim.f
src/ncpe_pkg.sv
src/ncpe_ram.sv
src/ncpe_div.sv
src/nurbs_curve_point_evaluator_unit.sv
sim/tb.sv
